// ===== hw/rtl/stt_pkg.sv =====
package stt_pkg;

    localparam int ID_W    = 5;
    localparam int COUNT_W = 32;
    localparam int MASK_W  = 32;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_SET   = 3'd1,
        ACT_KILL  = 3'd2,
        ACT_GET   = 3'd3,
        ACT_DELAY = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GET_WAIT,
        ST_TICK,
        ST_FINISH
    } state_t;

endpackage

// ===== hw/rtl/stt_count_ram.sv =====
module stt_count_ram
    import stt_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [COUNT_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [COUNT_W-1:0] rdata
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/stt_slot_search.sv =====
module stt_slot_search
    import stt_pkg::*;
#(
    parameter int NUM_SLOTS = 8,
    parameter int IW        = 3
)
(
    input  logic [ID_W-1:0] flags [NUM_SLOTS],
    input  logic [ID_W-1:0] id,
    output logic            match_hit,
    output logic [IW-1:0]   match_idx,
    output logic            free_hit,
    output logic [IW-1:0]   free_idx
);

    // Scanning downward leaves the lowest matching or free slot selected.
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        free_hit  = 1'b0;
        free_idx  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (flags[i] == id)
            begin
                match_hit = 1'b1;
                match_idx = IW'(i);
            end
            if (flags[i] == '0)
            begin
                free_hit = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

endmodule

// ===== hw/rtl/soft_timer_table_core.sv =====
// Table of countdown timers with one delay counter.
// Input channel (in_valid / in_stall) carries action, timer_id and time_value;
// a transaction is taken when in_valid is high and in_stall is low. Each input
// transaction produces exactly one result transaction on the output channel
// (out_valid / out_stall): fired_mask, read_time, found, table_full and
// delay_active.
// From input acceptance to out_valid, set, kill, load delay and unused actions
// pass through ST_EXEC and ST_FINISH; get adds ST_GET_WAIT for one count memory
// read, and a tick runs ST_TICK, which sweeps the count memory with one read and
// one write-back per cycle. The next input is taken the cycle after a result is
// loaded, and no new input is taken while an earlier one is still in progress.
// The result sits in an output register; a stalled receiver holds it, and a
// new input may still be accepted and processed up to the point where its
// result is ready, where the block waits until the register is free.
// Reset frees every slot, clears the delay counter and empties the output
// register. Counts live in a memory that needs no clearing pass.
module soft_timer_table_core
    import stt_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [COUNT_W-1:0] time_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [MASK_W-1:0]  fired_mask,
    output logic [COUNT_W-1:0] read_time,
    output logic               found,
    output logic               table_full,
    output logic               delay_active
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    state_t             state_reg, state_next;
    action_t            act_reg;
    logic [ID_W-1:0]    id_reg;
    logic [COUNT_W-1:0] tval_reg;

    logic [ID_W-1:0]    flag_reg  [NUM_SLOTS];
    logic [ID_W-1:0]    flag_next [NUM_SLOTS];
    logic [COUNT_W-1:0] delay_reg, delay_next;

    logic [CW-1:0]      tick_cnt_reg, tick_cnt_next;
    logic               proc_vld_reg, proc_vld_next;
    logic [IW-1:0]      proc_idx_reg, proc_idx_next;

    logic [MASK_W-1:0]  res_fired_reg, res_fired_next;
    logic [COUNT_W-1:0] res_time_reg, res_time_next;
    logic               res_found_reg, res_found_next;
    logic               res_full_reg, res_full_next;

    logic               out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]  fired_mask_reg, fired_mask_next;
    logic [COUNT_W-1:0] read_time_reg, read_time_next;
    logic               found_reg, found_next;
    logic               table_full_reg, table_full_next;
    logic               delay_active_reg, delay_active_next;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IW-1:0]      mem_raddr;
    logic [COUNT_W-1:0] mem_rdata;

    logic               match_hit, free_hit;
    logic [IW-1:0]      match_idx, free_idx;
    logic               in_take;

    stt_count_ram #(
        .DEPTH (NUM_SLOTS),
        .AW    (IW)
    ) u_count_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    stt_slot_search #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_slot_search (
        .flags     (flag_reg),
        .id        (id_reg),
        .match_hit (match_hit),
        .match_idx (match_idx),
        .free_hit  (free_hit),
        .free_idx  (free_idx)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            delay_reg        <= '0;
            tick_cnt_reg     <= '0;
            proc_vld_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                flag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            delay_reg        <= delay_next;
            tick_cnt_reg     <= tick_cnt_next;
            proc_vld_reg     <= proc_vld_next;
            out_valid_reg    <= out_valid_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                flag_reg[i] <= flag_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            act_reg  <= action_t'(action);
            id_reg   <= timer_id;
            tval_reg <= time_value;
        end
        proc_idx_reg     <= proc_idx_next;
        res_fired_reg    <= res_fired_next;
        res_time_reg     <= res_time_next;
        res_found_reg    <= res_found_next;
        res_full_reg     <= res_full_next;
        fired_mask_reg   <= fired_mask_next;
        read_time_reg    <= read_time_next;
        found_reg        <= found_next;
        table_full_reg   <= table_full_next;
        delay_active_reg <= delay_active_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        flag_next         = flag_reg;
        delay_next        = delay_reg;
        tick_cnt_next     = tick_cnt_reg;
        proc_vld_next     = proc_vld_reg;
        proc_idx_next     = proc_idx_reg;
        res_fired_next    = res_fired_reg;
        res_time_next     = res_time_reg;
        res_found_next    = res_found_reg;
        res_full_next     = res_full_reg;
        out_valid_next    = out_valid_reg && out_stall;
        fired_mask_next   = fired_mask_reg;
        read_time_next    = read_time_reg;
        found_next        = found_reg;
        table_full_next   = table_full_reg;
        delay_active_next = delay_active_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = tval_reg;
        mem_re            = 1'b0;
        mem_raddr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_fired_next = '0;
                res_time_next  = '0;
                res_found_next = 1'b0;
                res_full_next  = 1'b0;
                state_next     = ST_FINISH;
                unique case (act_reg)
                    ACT_TICK:
                    begin
                        if (delay_reg != '0)
                        begin
                            delay_next = delay_reg - COUNT_W'(1);
                        end
                        tick_cnt_next = '0;
                        proc_vld_next = 1'b0;
                        state_next    = ST_TICK;
                    end
                    ACT_SET:
                    begin
                        if (id_reg != '0)
                        begin
                            if (match_hit)
                            begin
                                res_found_next = 1'b1;
                                mem_we         = 1'b1;
                                mem_waddr      = match_idx;
                            end
                            else if (free_hit)
                            begin
                                flag_next[free_idx] = id_reg;
                                mem_we              = 1'b1;
                                mem_waddr           = free_idx;
                            end
                            else
                            begin
                                res_full_next = 1'b1;
                            end
                        end
                    end
                    ACT_KILL:
                    begin
                        if (id_reg != '0 && match_hit)
                        begin
                            res_found_next       = 1'b1;
                            flag_next[match_idx] = '0;
                        end
                    end
                    ACT_GET:
                    begin
                        if (id_reg != '0 && match_hit)
                        begin
                            res_found_next = 1'b1;
                            mem_re         = 1'b1;
                            mem_raddr      = match_idx;
                            state_next     = ST_GET_WAIT;
                        end
                    end
                    ACT_DELAY:
                    begin
                        delay_next = tval_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_GET_WAIT:
            begin
                res_time_next = mem_rdata;
                state_next    = ST_FINISH;
            end

            // Read slot k while writing back slot k - 1 from the previous read.
            ST_TICK:
            begin
                if (proc_vld_reg && flag_reg[proc_idx_reg] != '0)
                begin
                    if (mem_rdata != '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = proc_idx_reg;
                        mem_wdata = mem_rdata - COUNT_W'(1);
                    end
                    else
                    begin
                        res_fired_next = res_fired_reg
                                       | (MASK_W'(1) << flag_reg[proc_idx_reg]);
                        flag_next[proc_idx_reg] = '0;
                    end
                end
                if (tick_cnt_reg < CW'(NUM_SLOTS))
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = tick_cnt_reg[IW-1:0];
                    proc_vld_next = 1'b1;
                    proc_idx_next = tick_cnt_reg[IW-1:0];
                    tick_cnt_next = tick_cnt_reg + CW'(1);
                end
                else
                begin
                    proc_vld_next = 1'b0;
                    state_next    = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    fired_mask_next   = res_fired_reg;
                    read_time_next    = res_time_reg;
                    found_next        = res_found_reg;
                    table_full_next   = res_full_reg;
                    delay_active_next = (delay_reg != '0);
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign fired_mask   = fired_mask_reg;
    assign read_time    = read_time_reg;
    assign found        = found_reg;
    assign table_full   = table_full_reg;
    assign delay_active = delay_active_reg;

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finished transaction");

    a_found_full_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && table_full_reg))
        else $error("found and table_full both set");

    a_no_zero_flag_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !fired_mask_reg[0])
        else $error("timer number zero fired");

    a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("count memory read and write hit the same slot");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK) |-> (tick_cnt_reg <= CW'(NUM_SLOTS)))
        else $error("tick sweep ran past the last slot");

endmodule

// ===== dv/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int SLOTS        = 8;
    localparam int RANDOM_ITEMS = 790;

    // Action codes that the block must treat as no-ops.
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [MASK_W-1:0]  fired;
        logic [COUNT_W-1:0] rtime;
        logic               found;
        logic               full;
        logic               delay_on;
    } outcome_t;

    typedef struct packed {
        logic [2:0]         act;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] tval;
        logic               typed;
        outcome_t           want;
    } request_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic [ID_W-1:0]    timer_id;
    logic [COUNT_W-1:0] time_value;
    logic               out_valid;
    logic               out_stall;
    logic [MASK_W-1:0]  fired_mask;
    logic [COUNT_W-1:0] read_time;
    logic               found;
    logic               table_full;
    logic               delay_active;

    // Shadow of the timer table.
    logic [ID_W-1:0]    slot_num [SLOTS];
    logic [COUNT_W-1:0] slot_cnt [SLOTS];
    logic [COUNT_W-1:0] delay_cnt;

    request_t           pending_requests[$];
    outcome_t           awaited_outcomes[$];
    request_t           cur_req;
    outcome_t           got;
    logic [ID_W-1:0]    id_pool [12];

    int mismatches  = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_ticks     = 0;
    int n_expired   = 0;
    int n_full      = 0;
    int n_hits      = 0;
    int stall_left  = 0;
    int stall_mode  = 0;

    soft_timer_table_core #(
        .NUM_SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .timer_id(timer_id),
        .time_value(time_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .fired_mask(fired_mask),
        .read_time(read_time),
        .found(found),
        .table_full(table_full),
        .delay_active(delay_active)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic outcome_t mk_outcome(logic [MASK_W-1:0] fired, logic [COUNT_W-1:0] rtime,
                                            logic fnd, logic full, logic delay_on);
        outcome_t r;
        r.fired    = fired;
        r.rtime    = rtime;
        r.found    = fnd;
        r.full     = full;
        r.delay_on = delay_on;
        return r;
    endfunction

    function automatic void add_request(logic [2:0] act, logic [ID_W-1:0] id,
                                        logic [COUNT_W-1:0] tval, logic typed, outcome_t want);
        request_t r;
        r.act   = act;
        r.id    = id;
        r.tval  = tval;
        r.typed = typed;
        r.want  = want;
        pending_requests.push_back(r);
    endfunction

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic outcome_t advance_table(logic [2:0] act, logic [ID_W-1:0] id,
                                               logic [COUNT_W-1:0] tval);
        outcome_t r;
        int       i;
        int       hit;
        int       free_slot;
        r         = '0;
        hit       = -1;
        free_slot = -1;
        if (act == ACT_TICK)
        begin
            if (delay_cnt != 0)
                delay_cnt = delay_cnt - 1;
            for (i = 0; i < SLOTS; i++)
            begin
                if (slot_num[i] != 0)
                begin
                    if (slot_cnt[i] != 0)
                        slot_cnt[i] = slot_cnt[i] - 1;
                    else
                    begin
                        r.fired[slot_num[i]] = 1'b1;
                        slot_num[i] = '0;
                    end
                end
            end
        end
        else if (act == ACT_DELAY)
            delay_cnt = tval;
        else if (id != 0 && (act == ACT_SET || act == ACT_KILL || act == ACT_GET))
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                if (hit < 0 && slot_num[i] == id)
                    hit = i;
                if (free_slot < 0 && slot_num[i] == 0)
                    free_slot = i;
            end
            r.found = (hit >= 0);
            if (act == ACT_SET)
            begin
                if (hit >= 0)
                    slot_cnt[hit] = tval;
                else if (free_slot >= 0)
                begin
                    slot_num[free_slot] = id;
                    slot_cnt[free_slot] = tval;
                end
                else
                    r.full = 1'b1;
            end
            else if (act == ACT_KILL && hit >= 0)
                slot_num[hit] = '0;
            else if (act == ACT_GET && hit >= 0)
                r.rtime = slot_cnt[hit];
        end
        r.delay_on = (delay_cnt != 0);
        return r;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return id_pool[$urandom_range(0, 11)];
        else if (p < 96)
            return ID_W'($urandom_range(1, 31));
        return '0;
    endfunction

    // Mostly short counts so timers actually expire; some full-width ones sit in the table.
    function automatic logic [COUNT_W-1:0] pick_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return $urandom_range(0, 6);
        else if (p < 85)
            return $urandom_range(7, 60);
        return $urandom();
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, seen);
        end
    endtask

    // Receiver stalls follow their own pattern, switching mode every so often.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 150);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                n_accepted++;
                if (cur_req.typed)
                begin
                    void'(advance_table(cur_req.act, cur_req.id, cur_req.tval));
                    awaited_outcomes.push_back(cur_req.want);
                end
                else
                    awaited_outcomes.push_back(advance_table(cur_req.act, cur_req.id,
                                                             cur_req.tval));
            end
            if (out_valid && !out_stall)
            begin
                n_results++;
                got = mk_outcome(fired_mask, read_time, found, table_full, delay_active);
                if (awaited_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: %p", $realtime, got);
                end
                else
                begin
                    outcome_t want;
                    want = awaited_outcomes.pop_front();
                    check_field("fired_mask", want.fired, got.fired);
                    check_field("read_time", want.rtime, got.rtime);
                    check_field("found", 32'(want.found), 32'(got.found));
                    check_field("table_full", 32'(want.full), 32'(got.full));
                    check_field("delay_active", 32'(want.delay_on), 32'(got.delay_on));
                    n_expired += $countones(want.fired);
                    n_full    += int'(want.full);
                    n_hits    += int'(want.found);
                    if (want.fired != 0)
                        n_ticks++;
                end
            end
        end
    end

    initial
    begin : stimulus
        request_t req;
        int       burst;
        int       gap;
        int       n_useful;
        int       p;
        int       i;
        logic [2:0]      act;
        logic [ID_W-1:0] id;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = '0;
        timer_id   = '0;
        time_value = '0;
        cur_req    = '0;
        delay_cnt  = '0;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_num[i] = '0;
            slot_cnt[i] = '0;
        end
        for (i = 0; i < 12; i++)
            id_pool[i] = ID_W'($urandom_range(1, 31));

        // Directed part: empty table, timer number zero, spare actions, delay counter,
        // expiry of a zero count, filling the table, rewrite, read-back and kill.
        add_request(ACT_TICK, 5'd0, 32'h0, 1'b1, mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_SET, 5'd0, 32'hFFFF_FFFF, 1'b1,
                    mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_KILL, 5'd0, 32'h0, 1'b1, mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_GET, 5'd0, 32'h0, 1'b1, mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_SPARE_5, 5'd31, 32'hFFFF_FFFF, 1'b1,
                    mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_SPARE_6, 5'd31, 32'hFFFF_FFFF, 1'b1,
                    mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_SPARE_7, 5'd31, 32'hFFFF_FFFF, 1'b1,
                    mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_DELAY, 5'd0, 32'hFFFF_FFFF, 1'b1,
                    mk_outcome('0, '0, 1'b0, 1'b0, 1'b1));
        add_request(ACT_TICK, 5'd0, 32'h0, 1'b1, mk_outcome('0, '0, 1'b0, 1'b0, 1'b1));
        add_request(ACT_DELAY, 5'd0, 32'h1, 1'b1, mk_outcome('0, '0, 1'b0, 1'b0, 1'b1));
        add_request(ACT_TICK, 5'd0, 32'h0, 1'b1, mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_SET, 5'd31, 32'h0, 1'b1, mk_outcome('0, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_TICK, 5'd0, 32'h0, 1'b1,
                    mk_outcome(32'h8000_0000, '0, 1'b0, 1'b0, 1'b0));
        add_request(ACT_SET, 5'd1, 32'h2, 1'b0, '0);
        add_request(ACT_SET, 5'd2, 32'h2, 1'b0, '0);
        add_request(ACT_SET, 5'd4, 32'h2, 1'b0, '0);
        add_request(ACT_SET, 5'd8, 32'h2, 1'b0, '0);
        add_request(ACT_SET, 5'd16, 32'h2, 1'b0, '0);
        add_request(ACT_SET, 5'd30, 32'h2, 1'b0, '0);
        add_request(ACT_SET, 5'd21, 32'h2, 1'b0, '0);
        add_request(ACT_SET, 5'd10, 32'h2, 1'b0, '0);
        add_request(ACT_SET, 5'd3, 32'h5, 1'b1, mk_outcome('0, '0, 1'b0, 1'b1, 1'b0));
        add_request(ACT_SET, 5'd1, 32'hFFFF_FFFF, 1'b1,
                    mk_outcome('0, '0, 1'b1, 1'b0, 1'b0));
        add_request(ACT_GET, 5'd1, 32'h0, 1'b1,
                    mk_outcome('0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
        add_request(ACT_KILL, 5'd10, 32'h0, 1'b1, mk_outcome('0, '0, 1'b1, 1'b0, 1'b0));
        add_request(ACT_TICK, 5'd0, 32'h0, 1'b0, '0);

        // Random part. Occasional runs of sets push the table toward full.
        n_useful = 0;
        while (n_useful < RANDOM_ITEMS)
        begin
            p = $urandom_range(0, 99);
            if (p < 4)
            begin
                repeat ($urandom_range(6, 10))
                begin
                    add_request(ACT_SET, ID_W'($urandom_range(1, 31)), pick_count(),
                                1'b0, '0);
                    n_useful++;
                end
            end
            else
            begin
                id = pick_id();
                if (p < 36)
                    act = ACT_TICK;
                else if (p < 62)
                    act = ACT_SET;
                else if (p < 74)
                    act = ACT_GET;
                else if (p < 84)
                    act = ACT_KILL;
                else if (p < 97)
                    act = ACT_DELAY;
                else
                begin
                    case ($urandom_range(0, 2))
                        0: act = ACT_SPARE_5;
                        1: act = ACT_SPARE_6;
                        default: act = ACT_SPARE_7;
                    endcase
                end
                if (act == ACT_DELAY)
                    add_request(act, id, ($urandom_range(0, 4) == 0) ? $urandom()
                                : $urandom_range(0, 100), 1'b0, '0);
                else if (act == ACT_SET)
                    add_request(act, id, pick_count(), 1'b0, '0);
                else
                    add_request(act, id, $urandom(), 1'b0, '0);
                if (act == ACT_TICK || act == ACT_DELAY
                    || (id != 0 && act != ACT_SPARE_5 && act != ACT_SPARE_6
                        && act != ACT_SPARE_7))
                    n_useful++;
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        burst = 0;
        while (pending_requests.size() != 0)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            req = pending_requests.pop_front();
            in_valid   <= 1'b1;
            action     <= req.act;
            timer_id   <= req.id;
            time_value <= req.tval;
            cur_req    <= req;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            burst--;
            @(negedge clk);
        end
        in_valid <= 1'b0;

        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 20) @(posedge clk);

        $display("Ran %0d transactions in, %0d results out; %0d timers expired on %0d ticks,",
                 n_accepted, n_results, n_expired, n_ticks);
        $display("%0d requests found their timer and %0d sets hit a full table.", n_hits, n_full);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Timed out with %0d results outstanding", awaited_outcomes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/stt_pkg.sv
hw/rtl/stt_count_ram.sv
hw/rtl/stt_slot_search.sv
hw/rtl/soft_timer_table_core.sv
dv/testbench.sv
